/* src/segalloc_pkg.sv */
// ----------------------------------------------------------------------------
// segalloc_pkg
// Shared types and codes of the segment allocator: sequencer states,
// status codes, fit modes, request functions, register indexes and default sizing.
// ----------------------------------------------------------------------------
package segalloc_pkg;

  // Default sizing
  localparam int DefMaxSegments = 64;
  localparam int DefAddrBits    = 20;

  // Configuration port shape
  localparam int CfgDataW = 21;
  localparam int CfgIdxW  = 1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_MEM_SIZE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIT_MODE = 1'd1;

  // Request functions
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Fit modes
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_NEXT  = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOFIT    = 2'd1;
  localparam logic [1:0] STAT_NOTALLOC = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_WR_HI,
    ST_WR_LO,
    ST_RESP
  } state_e;

endpackage

/* src/segalloc_if.sv */
// ----------------------------------------------------------------------------
// segalloc_if
// Valid/ready channels of the segment allocator: request and response.
// ----------------------------------------------------------------------------
interface segalloc_req_if #(
  parameter int ADDR_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [ADDR_BITS:0]   request_size;
  logic [ADDR_BITS-1:0] block_address;

  modport source (output valid, func, request_size, block_address, input ready);
  modport sink   (input valid, func, request_size, block_address, output ready);
endinterface

interface segalloc_rsp_if #(
  parameter int ADDR_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ADDR_BITS-1:0] granted_address;
  logic [ADDR_BITS:0]   freed_size;

  modport source (output valid, status, granted_address, freed_size, input ready);
  modport sink   (input valid, status, granted_address, freed_size, output ready);
endinterface

/* src/segalloc_table.sv */
// ----------------------------------------------------------------------------
// segalloc_table
// Segment table storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module segalloc_table #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 42
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/segment_allocator_with_coalescing.sv */
// ----------------------------------------------------------------------------
// segment_allocator_with_coalescing
// Address-ordered segment table with first, next or best fit allocation and
// free with merging of free neighbors.
// ----------------------------------------------------------------------------
// One request is in flight at a time. Every request but a zero-size allocate
// scans all N live segments through the table's single read port, then an
// allocate that splits or a free moves the entries above the change by one
// read and one write a cycle, plus one or two table writes and a response
// state. After reset and after every memory_size write the block rebuilds
// entry 0 before it takes a request. A finished response waits in an output
// register, so the next request is taken while it is still unclaimed.
module segment_allocator_with_coalescing
  import segalloc_pkg::*;
#(
  parameter int MAX_SEGMENTS = DefMaxSegments,
  parameter int ADDR_BITS    = DefAddrBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  segalloc_req_if.sink        req_i,
  segalloc_rsp_if.source      rsp_o
);

  localparam int AddrW = ADDR_BITS;
  localparam int SizeW = ADDR_BITS + 1;
  localparam int IdxW  = $clog2(MAX_SEGMENTS);
  localparam int CntW  = $clog2(MAX_SEGMENTS + 1);
  localparam int EntW  = 1 + SizeW + AddrW;
  localparam logic [63:0] CapSize = 64'(1) << ADDR_BITS;
  localparam logic [63:0] RstSize = (ADDR_BITS >= 20) ? 64'(1048576) : CapSize;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SEGMENTS);

  typedef struct packed {
    logic             used;
    logic [SizeW-1:0] len;
    logic [AddrW-1:0] start;
  } seg_t;

  state_e state_q, state_d;

  logic             init_q, init_d;
  logic [SizeW-1:0] msize_q, msize_d;
  logic [1:0]       mode_q, mode_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  rover_q, rover_d;

  logic             func_q, func_d;
  logic [SizeW-1:0] want_q, want_d;
  logic [AddrW-1:0] addr_q, addr_d;

  logic [IdxW-1:0]  pos_q, pos_d;
  logic [CntW-1:0]  n_q, n_d;
  logic             pv_q, pv_d;
  logic [IdxW-1:0]  pa_q, pa_d;

  logic             found_q, found_d;
  logic [IdxW-1:0]  k_q, k_d;
  seg_t             kent_q, kent_d;
  seg_t             prev_q, prev_d;
  seg_t             hp_q, hp_d;
  logic             hp_ok_q, hp_ok_d;
  seg_t             nxt_q, nxt_d;
  logic             nxt_ok_q, nxt_ok_d;
  logic             cap_q, cap_d;

  logic             up_q, up_d;
  logic [1:0]       r_q, r_d;
  logic [IdxW-1:0]  lo_idx_q, lo_idx_d;
  seg_t             lo_ent_q, lo_ent_d;
  seg_t             hi_ent_q, hi_ent_d;

  logic [1:0]       stat_q, stat_d;
  logic [AddrW-1:0] gaddr_q, gaddr_d;
  logic [SizeW-1:0] fsize_q, fsize_d;

  logic             rsp_v_q, rsp_v_d;
  logic [1:0]       rsp_stat_q, rsp_stat_d;
  logic [AddrW-1:0] rsp_gaddr_q, rsp_gaddr_d;
  logic [SizeW-1:0] rsp_fsize_q, rsp_fsize_d;

  // Table ports
  logic             tb_we, tb_re;
  logic [IdxW-1:0]  tb_waddr, tb_raddr;
  seg_t             tb_wdata;
  logic [EntW-1:0]  tb_rdata;
  seg_t             rd_ent;

  logic req_acc, rsp_free;
  logic alloc_split, alloc_full;

  // Sizing of a memory_size write
  logic [SizeW:0]   cfg_sz0;
  logic [SizeW-1:0] cfg_size;

  // Merge working values
  logic             pm, nm;
  logic [IdxW-1:0]  tgt;
  logic [SizeW-1:0] merged;
  logic [1:0]       rcnt;
  logic [CntW-1:0]  src0;
  logic [CntW-1:0]  mc;
  logic [IdxW-1:0]  mrv;
  logic [CntW-1:0]  kp1;
  logic [CntW-1:0]  rv_alloc;
  logic             fit;

  segalloc_table #(
    .DEPTH (MAX_SEGMENTS),
    .WIDTH (EntW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tb_we),
    .waddr_i (tb_waddr),
    .wdata_i (tb_wdata),
    .re_i    (tb_re),
    .raddr_i (tb_raddr),
    .rdata_o (tb_rdata)
  );

  assign rd_ent   = tb_rdata;
  assign req_acc  = req_i.valid && req_i.ready;
  assign rsp_free = !rsp_v_q || rsp_o.ready;

  // Allocation decision on the chosen segment
  assign alloc_split = kent_q.len > want_q;
  assign alloc_full  = alloc_split && (cnt_q >= MaxCnt);
  assign kp1         = CntW'(k_q) + CntW'(1);

  // Saturated memory size from the config data
  always_comb begin
    cfg_sz0  = (cfg_data_i == '0) ? (SizeW + 1)'(1) : (SizeW + 1)'(cfg_data_i);
    cfg_size = (64'(cfg_sz0) > CapSize) ? SizeW'(CapSize) : SizeW'(cfg_sz0);
  end

  // Neighbor merge plan for a free
  always_comb begin
    pm     = hp_ok_q && !hp_q.used;
    nm     = nxt_ok_q && !nxt_q.used;
    tgt    = pm ? (k_q - IdxW'(1)) : k_q;
    merged = kent_q.len + (pm ? hp_q.len : '0) + (nm ? nxt_q.len : '0);
    rcnt   = {1'b0, pm} + {1'b0, nm};
    src0   = CntW'(tgt) + CntW'(1) + CntW'(rcnt);
    mrv    = rover_q;
    mc     = cnt_q;
    if (pm) begin
      if (mrv > k_q) begin
        mrv = mrv - IdxW'(1);
      end
      mc = mc - CntW'(1);
      if (CntW'(mrv) >= mc) begin
        mrv = '0;
      end
    end
    if (nm) begin
      if (mrv > (tgt + IdxW'(1))) begin
        mrv = mrv - IdxW'(1);
      end
      mc = mc - CntW'(1);
      if (CntW'(mrv) >= mc) begin
        mrv = '0;
      end
    end
    rv_alloc = (kp1 >= (cnt_q + (alloc_split ? CntW'(1) : CntW'(0)))) ? '0 : kp1;
  end

  // Fit test on the entry coming back from the table
  assign fit = !rd_ent.used && (rd_ent.len >= want_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          if (req_i.func == FUNC_ALLOC && req_i.request_size == '0) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (n_q == '0 && !pv_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!found_q) begin
          state_d = ST_RESP;
        end else if (func_q == FUNC_FREE) begin
          state_d = ST_SHIFT;
        end else if (alloc_full) begin
          state_d = ST_RESP;
        end else if (alloc_split) begin
          state_d = ST_SHIFT;
        end else begin
          state_d = ST_WR_LO;
        end
      end
      ST_SHIFT: begin
        if (n_q == '0 && !pv_q) begin
          state_d = (func_q == FUNC_ALLOC) ? ST_WR_HI : ST_WR_LO;
        end
      end
      ST_WR_HI: state_d = ST_WR_LO;
      ST_WR_LO: state_d = ST_RESP;
      ST_RESP: begin
        if (rsp_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and control registers
  always_comb begin
    init_d      = init_q;
    msize_d     = msize_q;
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    rover_d     = rover_q;
    func_d      = func_q;
    want_d      = want_q;
    addr_d      = addr_q;
    pos_d       = pos_q;
    n_d         = n_q;
    pv_d        = 1'b0;
    pa_d        = pa_q;
    found_d     = found_q;
    k_d         = k_q;
    kent_d      = kent_q;
    prev_d      = prev_q;
    hp_d        = hp_q;
    hp_ok_d     = hp_ok_q;
    nxt_d       = nxt_q;
    nxt_ok_d    = nxt_ok_q;
    cap_d       = cap_q;
    up_d        = up_q;
    r_d         = r_q;
    lo_idx_d    = lo_idx_q;
    lo_ent_d    = lo_ent_q;
    hi_ent_d    = hi_ent_q;
    stat_d      = stat_q;
    gaddr_d     = gaddr_q;
    fsize_d     = fsize_q;
    rsp_v_d     = rsp_v_q && !rsp_o.ready;
    rsp_stat_d  = rsp_stat_q;
    rsp_gaddr_d = rsp_gaddr_q;
    rsp_fsize_d = rsp_fsize_q;

    case (state_q)
      ST_IDLE: begin
        if (init_q) begin
          init_d = 1'b0;
        end
        if (req_acc) begin
          func_d   = req_i.func;
          want_d   = req_i.request_size;
          addr_d   = req_i.block_address;
          n_d      = cnt_q;
          pos_d    = (req_i.func == FUNC_ALLOC && mode_q == FIT_NEXT &&
                      CntW'(rover_q) < cnt_q) ? rover_q : '0;
          found_d  = 1'b0;
          cap_d    = 1'b0;
          hp_ok_d  = 1'b0;
          nxt_ok_d = 1'b0;
          stat_d   = (req_i.func == FUNC_ALLOC && req_i.request_size == '0) ?
                     STAT_NOFIT : STAT_OK;
          gaddr_d  = '0;
          fsize_d  = '0;
        end
      end
      ST_SCAN: begin
        // issue one read a cycle, wrapping at the live count
        if (n_q != '0) begin
          n_d  = n_q - CntW'(1);
          pv_d = 1'b1;
          pa_d = pos_q;
          pos_d = ((CntW'(pos_q) + CntW'(1)) >= cnt_q) ? '0 : (pos_q + IdxW'(1));
        end
        // evaluate the entry read last cycle
        if (pv_q) begin
          if (func_q == FUNC_ALLOC) begin
            if (fit && (!found_q || (mode_q == FIT_BEST && rd_ent.len < kent_q.len))) begin
              found_d = 1'b1;
              k_d     = pa_q;
              kent_d  = rd_ent;
            end
          end else begin
            if (cap_q) begin
              nxt_d    = rd_ent;
              nxt_ok_d = 1'b1;
              cap_d    = 1'b0;
            end
            if (!found_q && rd_ent.used && rd_ent.start == addr_q) begin
              found_d = 1'b1;
              k_d     = pa_q;
              kent_d  = rd_ent;
              hp_d    = prev_q;
              hp_ok_d = (pa_q != '0);
              cap_d   = 1'b1;
            end
            prev_d = rd_ent;
          end
        end
      end
      ST_DECIDE: begin
        if (!found_q) begin
          stat_d = (func_q == FUNC_ALLOC) ? STAT_NOFIT : STAT_NOTALLOC;
        end else if (func_q == FUNC_FREE) begin
          lo_idx_d = tgt;
          lo_ent_d = '{used: 1'b0, len: merged, start: pm ? hp_q.start : kent_q.start};
          up_d     = 1'b0;
          r_d      = rcnt;
          pos_d    = IdxW'(src0);
          n_d      = cnt_q - src0;
          cnt_d    = cnt_q - CntW'(rcnt);
          rover_d  = mrv;
          fsize_d  = merged;
        end else if (alloc_full) begin
          stat_d = STAT_FULL;
        end else begin
          lo_idx_d = k_q;
          gaddr_d  = kent_q.start;
          rover_d  = IdxW'(rv_alloc);
          if (alloc_split) begin
            lo_ent_d = '{used: 1'b1, len: want_q, start: kent_q.start};
            hi_ent_d = '{used: 1'b0, len: kent_q.len - want_q,
                         start: kent_q.start + AddrW'(want_q)};
            up_d     = 1'b1;
            pos_d    = IdxW'(cnt_q - CntW'(1));
            n_d      = cnt_q - kp1;
            cnt_d    = cnt_q + CntW'(1);
          end else begin
            lo_ent_d = '{used: 1'b1, len: kent_q.len, start: kent_q.start};
          end
        end
      end
      ST_SHIFT: begin
        if (n_q != '0) begin
          n_d   = n_q - CntW'(1);
          pv_d  = 1'b1;
          pa_d  = pos_q;
          pos_d = up_q ? (pos_q - IdxW'(1)) : (pos_q + IdxW'(1));
        end
      end
      ST_RESP: begin
        if (rsp_free) begin
          rsp_v_d     = 1'b1;
          rsp_stat_d  = stat_q;
          rsp_gaddr_d = gaddr_q;
          rsp_fsize_d = fsize_q;
        end
      end
      default: ;
    endcase

    // the user must write configuration only while idle; the block itself does not enforce it
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MEM_SIZE: begin
          msize_d = cfg_size;
          init_d  = 1'b1;
          cnt_d   = CntW'(1);
          rover_d = '0;
        end
        CFG_FIT_MODE: mode_d = cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Outputs: handshake and table ports
  always_comb begin
    req_i.ready = (state_q == ST_IDLE) && !init_q;
    tb_we    = 1'b0;
    tb_waddr = lo_idx_q;
    tb_wdata = lo_ent_q;
    tb_re    = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (n_q != '0);
    tb_raddr = pos_q;
    case (state_q)
      ST_IDLE: begin
        if (init_q) begin
          tb_we    = 1'b1;
          tb_waddr = '0;
          tb_wdata = '{used: 1'b0, len: msize_q, start: '0};
        end
      end
      ST_SHIFT: begin
        if (pv_q) begin
          tb_we    = 1'b1;
          tb_waddr = up_q ? (pa_q + IdxW'(1)) : (pa_q - IdxW'(r_q));
          tb_wdata = rd_ent;
        end
      end
      ST_WR_HI: begin
        tb_we    = 1'b1;
        tb_waddr = lo_idx_q + IdxW'(1);
        tb_wdata = hi_ent_q;
      end
      ST_WR_LO: tb_we = 1'b1;
      default: ;
    endcase
  end

  assign rsp_o.valid           = rsp_v_q;
  assign rsp_o.status          = rsp_stat_q;
  assign rsp_o.granted_address = rsp_gaddr_q;
  assign rsp_o.freed_size      = rsp_fsize_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      init_q  <= 1'b1;
      msize_q <= SizeW'(RstSize);
      mode_q  <= FIT_BEST;
      cnt_q   <= CntW'(1);
      rover_q <= '0;
      pv_q    <= 1'b0;
      n_q     <= '0;
      rsp_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      msize_q <= msize_d;
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      rover_q <= rover_d;
      pv_q    <= pv_d;
      n_q     <= n_d;
      rsp_v_q <= rsp_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    want_q      <= want_d;
    addr_q      <= addr_d;
    pos_q       <= pos_d;
    pa_q        <= pa_d;
    found_q     <= found_d;
    k_q         <= k_d;
    kent_q      <= kent_d;
    prev_q      <= prev_d;
    hp_q        <= hp_d;
    hp_ok_q     <= hp_ok_d;
    nxt_q       <= nxt_d;
    nxt_ok_q    <= nxt_ok_d;
    cap_q       <= cap_d;
    up_q        <= up_d;
    r_q         <= r_d;
    lo_idx_q    <= lo_idx_d;
    lo_ent_q    <= lo_ent_d;
    hi_ent_q    <= hi_ent_d;
    stat_q      <= stat_d;
    gaddr_q     <= gaddr_d;
    fsize_q     <= fsize_d;
    rsp_stat_q  <= rsp_stat_d;
    rsp_gaddr_q <= rsp_gaddr_d;
    rsp_fsize_q <= rsp_fsize_d;
  end

`ifndef SYNTH
  // live segment count stays within the table
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= MaxCnt))
    else $error("segment count out of range");

  // rover always points at a live entry when idle
  a_rover_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (CntW'(rover_q) < cnt_q))
    else $error("rover beyond live segments");

  // a table write during a move never lands beyond the live count
  a_shift_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && pv_q) |-> (CntW'(tb_waddr) < cnt_q))
    else $error("entry move outside table");
`endif

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segment allocator. Directed tests cover
// reset state, size extremes, the error codes and table overflow; random
// allocate/free traffic in every fit mode follows. Every response is checked
// against a behavioral model of the segment table kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import segalloc_pkg::*;

  localparam int NSEG  = 64;
  localparam int ABITS = 20;
  localparam int WDOG  = 20000;
  localparam logic [20:0] MEM_MAX = 21'd1048576;

  typedef struct packed {
    logic        func;
    logic [20:0] size;
    logic [19:0] addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] gaddr;
    logic [20:0] fsize;
  } rsp_t;

  // Directed row: request plus optional typed-in expectation
  typedef struct {
    logic        func;
    logic [20:0] size;
    logic [19:0] addr;
    logic        has_exp;
    rsp_t        exp_rsp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  segalloc_req_if #(.ADDR_BITS(ABITS)) req_if ();
  segalloc_rsp_if #(.ADDR_BITS(ABITS)) rsp_if ();

  segment_allocator_with_coalescing #(.MAX_SEGMENTS(NSEG), .ADDR_BITS(ABITS)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  always #1 clk_i = ~clk_i;

  // Segment table mirror
  logic [20:0] tbl_start [NSEG];
  logic [20:0] tbl_len [NSEG];
  logic        tbl_used [NSEG];
  int          tbl_cnt;
  int          rov;
  logic [20:0] mem_sz;
  logic [1:0]  mode;

  rsp_t rsp_queue[$];
  int   n_err = 0;
  int   idle_cycles = 0;
  bit   timed_out = 0;

  function automatic void table_init();
    tbl_start[0] = '0;
    tbl_len[0] = mem_sz;
    tbl_used[0] = 1'b0;
    tbl_cnt = 1;
    rov = 0;
  endfunction

  function automatic void drop_entry(int r);
    for (int i = r; i + 1 < tbl_cnt; i++) begin
      tbl_start[i] = tbl_start[i+1];
      tbl_len[i] = tbl_len[i+1];
      tbl_used[i] = tbl_used[i+1];
    end
    tbl_cnt--;
    if (rov > r) rov--;
    if (rov >= tbl_cnt) rov = 0;
  endfunction

  function automatic bit seg_fits(int i, logic [20:0] want);
    return !tbl_used[i] && tbl_len[i] >= want;
  endfunction

  function automatic int pick_segment(logic [20:0] want);
    int k;
    int best;
    k = tbl_cnt;
    best = tbl_cnt;
    if (mode == FIT_NEXT) begin
      k = (rov < tbl_cnt) ? rov : 0;
      for (int i = 0; i < tbl_cnt; i++) begin
        if (seg_fits(k, want)) return k;
        k = (k + 1 >= tbl_cnt) ? 0 : k + 1;
      end
      return tbl_cnt;
    end
    if (mode == FIT_BEST) begin
      for (int i = 0; i < tbl_cnt; i++)
        if (seg_fits(i, want) && (best == tbl_cnt || tbl_len[i] < tbl_len[best])) best = i;
      return best;
    end
    for (int i = 0; i < tbl_cnt; i++)
      if (seg_fits(i, want)) return i;
    return tbl_cnt;
  endfunction

  // Applies one request to the mirror and returns the expected response
  function automatic rsp_t predict_response(req_t r);
    rsp_t o;
    int k;
    o = '0;
    if (r.func == FUNC_ALLOC) begin
      if (r.size == 0) begin
        o.status = STAT_NOFIT;
        return o;
      end
      k = pick_segment(r.size);
      if (k >= tbl_cnt) begin
        o.status = STAT_NOFIT;
        return o;
      end
      if (tbl_len[k] > r.size) begin
        if (tbl_cnt >= NSEG) begin
          o.status = STAT_FULL;
          return o;
        end
        for (int i = tbl_cnt; i > k + 1; i--) begin
          tbl_start[i] = tbl_start[i-1];
          tbl_len[i] = tbl_len[i-1];
          tbl_used[i] = tbl_used[i-1];
        end
        tbl_start[k+1] = tbl_start[k] + r.size;
        tbl_len[k+1] = tbl_len[k] - r.size;
        tbl_used[k+1] = 1'b0;
        tbl_len[k] = r.size;
        tbl_cnt++;
      end
      tbl_used[k] = 1'b1;
      rov = (k + 1 >= tbl_cnt) ? 0 : k + 1;
      o.status = STAT_OK;
      o.gaddr = tbl_start[k][19:0];
    end else begin
      for (k = 0; k < tbl_cnt; k++)
        if (tbl_used[k] && tbl_start[k] == {1'b0, r.addr}) break;
      if (k >= tbl_cnt) begin
        o.status = STAT_NOTALLOC;
        return o;
      end
      tbl_used[k] = 1'b0;
      if (k > 0 && !tbl_used[k-1]) begin
        tbl_len[k-1] += tbl_len[k];
        drop_entry(k);
        k--;
      end
      if (k + 1 < tbl_cnt && !tbl_used[k+1]) begin
        tbl_len[k] += tbl_len[k+1];
        drop_entry(k + 1);
      end
      o.status = STAT_OK;
      o.fsize = tbl_len[k];
    end
    return o;
  endfunction

  // Pick a used segment start for a well-formed free, or a random address
  function automatic logic [19:0] used_address();
    int picks[$];
    for (int i = 0; i < tbl_cnt; i++)
      if (tbl_used[i]) picks.push_back(i);
    if (picks.size() == 0) return 20'($urandom);
    return tbl_start[picks[$urandom_range(0, picks.size() - 1)]][19:0];
  endfunction

  // Response checker; sampled at the rising edge
  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.status, rsp_if.granted_address, rsp_if.freed_size};
      if (rsp_queue.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected response beat: %p", got);
      end else begin
        want = rsp_queue.pop_front();
        if (got !== want) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: status exp %0d got %0d, addr exp %0h got %0h, size exp %0h got %0h",
                     want.status, got.status, want.gaddr, got.gaddr, want.fsize, got.fsize);
        end
      end
    end
  end

  // Sink side: random stalls, redrawn after each beat
  initial begin
    int gap;
    rsp_if.ready = 1'b0;
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      @(negedge clk_i);
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG && !timed_out) begin
      timed_out = 1;
      $display("Some tests failed");
      $finish;
    end
  end

  // Valid stays high into the next beat when no idle cycles are drawn
  task automatic send_beat(req_t r, bit has_exp, rsp_t exp_rsp);
    rsp_t p;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func <= r.func;
    req_if.request_size <= r.size;
    req_if.block_address <= r.addr;
    do @(posedge clk_i); while (!req_if.ready);
    p = predict_response(r);
    if (has_exp && p !== exp_rsp) begin
      n_err++;
      if (n_err <= 10) $display("model disagrees with table row: %p vs %p", p, exp_rsp);
    end
    rsp_queue.push_back(p);
    @(negedge clk_i);
  endtask

  // Idle the block, then write one register
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [20:0] val);
    req_if.valid <= 1'b0;
    while (rsp_queue.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MEM_SIZE) begin
      mem_sz = (val == 0) ? 21'd1 : (val > MEM_MAX ? MEM_MAX : val);
      table_init();
    end else mode = val[1:0];
    @(negedge clk_i);
  endtask

  task automatic run_random(int n, logic [20:0] max_sz);
    req_t r;
    for (int i = 0; i < n; i++) begin
      r = '0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          r.func = FUNC_ALLOC;
          r.size = 21'($urandom_range(1, max_sz));
          r.addr = 20'($urandom);
        end
        5, 6, 7: begin
          r.func = FUNC_FREE;
          r.addr = used_address();
          r.size = 21'($urandom);
        end
        default: begin
          r.func = 1'($urandom);
          r.size = 21'($urandom);
          r.addr = 20'($urandom);
        end
      endcase
      send_beat(r, 1'b0, '0);
    end
  endtask

  row_t rows[$];

  function automatic row_t mk(logic f, logic [20:0] s, logic [19:0] a, bit he, rsp_t e);
    row_t x;
    x.func = f; x.size = s; x.addr = a; x.has_exp = he; x.exp_rsp = e;
    return x;
  endfunction

  initial begin
    req_t r;
    req_if.valid = 1'b0;
    req_if.func = FUNC_ALLOC;
    req_if.request_size = '0;
    req_if.block_address = '0;
    mem_sz = MEM_MAX;
    mode = FIT_BEST;
    table_init();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows, reset config: whole memory, best fit
    rows.push_back(mk(FUNC_ALLOC, 21'd0, 20'd0, 1'b1, '{STAT_NOFIT, 20'd0, 21'd0}));
    rows.push_back(mk(FUNC_FREE, 21'd0, 20'd0, 1'b1, '{STAT_NOTALLOC, 20'd0, 21'd0}));
    rows.push_back(mk(FUNC_ALLOC, 21'h1FFFFF, 20'hFFFFF, 1'b1, '{STAT_NOFIT, 20'd0, 21'd0}));
    rows.push_back(mk(FUNC_ALLOC, MEM_MAX, 20'd0, 1'b1, '{STAT_OK, 20'd0, 21'd0}));
    rows.push_back(mk(FUNC_ALLOC, 21'd1, 20'd0, 1'b1, '{STAT_NOFIT, 20'd0, 21'd0}));
    rows.push_back(mk(FUNC_FREE, 21'h1FFFFF, 20'd0, 1'b1, '{STAT_OK, 20'd0, MEM_MAX}));
    rows.push_back(mk(FUNC_ALLOC, 21'd100, 20'd0, 1'b1, '{STAT_OK, 20'd0, 21'd0}));
    rows.push_back(mk(FUNC_ALLOC, 21'd50, 20'd0, 1'b1, '{STAT_OK, 20'd100, 21'd0}));
    rows.push_back(mk(FUNC_ALLOC, 21'd1, 20'd0, 1'b0, '0));
    rows.push_back(mk(FUNC_FREE, 21'd0, 20'd100, 1'b0, '0));
    rows.push_back(mk(FUNC_FREE, 21'd0, 20'd100, 1'b1, '{STAT_NOTALLOC, 20'd0, 21'd0}));
    rows.push_back(mk(FUNC_ALLOC, 21'd30, 20'd0, 1'b0, '0));
    rows.push_back(mk(FUNC_FREE, 21'd0, 20'd0, 1'b0, '0));
    rows.push_back(mk(FUNC_FREE, 21'd0, 20'd150, 1'b0, '0));
    rows.push_back(mk(FUNC_FREE, 21'd0, 20'hFFFFF, 1'b1, '{STAT_NOTALLOC, 20'd0, 21'd0}));
    foreach (rows[i]) begin
      r = '{rows[i].func, rows[i].size, rows[i].addr};
      send_beat(r, rows[i].has_exp, rows[i].exp_rsp);
    end

    // Table overflow: 63 one-unit grants fill the table, then splits are
    // refused while an exact fit of the remainder still succeeds
    write_reg(CFG_FIT_MODE, 21'(FIT_FIRST));
    write_reg(CFG_MEM_SIZE, 21'd200);
    for (int i = 0; i < 66; i++) send_beat('{FUNC_ALLOC, 21'd1, 20'd0}, 1'b0, '0);
    send_beat('{FUNC_ALLOC, 21'd136, 20'd0}, 1'b0, '0);
    send_beat('{FUNC_ALLOC, 21'd137, 20'd0}, 1'b0, '0);

    // Random phases across fit modes and memory sizes
    write_reg(CFG_MEM_SIZE, 21'd0);
    run_random(10, 21'd2);
    write_reg(CFG_FIT_MODE, 21'(FIT_NEXT));
    write_reg(CFG_MEM_SIZE, 21'd1000);
    run_random(200, 21'd60);
    write_reg(CFG_FIT_MODE, 21'(FIT_BEST));
    run_random(200, 21'd60);
    write_reg(CFG_FIT_MODE, 21'd3);
    write_reg(CFG_MEM_SIZE, 21'h1FFFFF);
    run_random(150, 21'd40000);
    write_reg(CFG_FIT_MODE, 21'(FIT_FIRST));
    write_reg(CFG_MEM_SIZE, 21'd300);
    run_random(150, 21'd20);
    write_reg(CFG_FIT_MODE, 21'(FIT_NEXT));
    write_reg(CFG_MEM_SIZE, MEM_MAX);
    run_random(60, 21'h1FFFFF);

    // Drain
    req_if.valid <= 1'b0;
    while (rsp_queue.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
    if (n_err == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
